FILE: src/osmt_pkg.sv
// Shared types and codes for the ordered set membership table.
package osmt_pkg;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int WINDOW   = 1 << INDEX_W;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      found;
        logic [COUNT_W-1:0]        member_count;
        logic signed [VALUE_W-1:0] read_value;
    } t_rsp;

    // token and running hit flag handed from cell to cell
    typedef struct packed {
        logic tok;
        logic hit;
    } t_link;

    // operation broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

    // where a cell sits relative to the fill level
    typedef struct packed {
        logic live;
        logic next_live;
        logic tail;
    } t_slot;

endpackage

FILE: src/osmt_cell.sv
// One table cell: holds an entry, compares it with the key, shifts or appends.
module osmt_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  osmt_pkg::t_link                    i_link,
    input  osmt_pkg::t_cell_ctl                i_ctl,
    input  osmt_pkg::t_slot                    i_slot,
    input  logic signed [osmt_pkg::VALUE_W-1:0] i_key,
    input  logic signed [osmt_pkg::VALUE_W-1:0] i_next_value,
    output osmt_pkg::t_link                    o_link,
    output logic signed [osmt_pkg::VALUE_W-1:0] o_value
);

    osmt_pkg::t_link                     r_link;
    osmt_pkg::t_link                     n_link;
    logic signed [osmt_pkg::VALUE_W-1:0] r_value;
    logic signed [osmt_pkg::VALUE_W-1:0] n_value;
    logic                                w_match;
    logic                                w_hit_here;

    always_comb begin
        w_match    = i_slot.live && (r_value == i_key);
        w_hit_here = i_link.hit | w_match;
        n_value    = r_value;
        if (i_link.tok) begin
            // removal at or before this cell pulls the right neighbor in
            if (i_ctl.remove && w_hit_here && i_slot.next_live) begin
                n_value = i_next_value;
            end else if (i_ctl.insert && i_slot.tail && !i_link.hit) begin
                n_value = i_key;
            end
        end
        n_link.tok = i_link.tok;
        n_link.hit = i_link.tok ? w_hit_here : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link  = r_link;
    assign o_value = r_value;

endmodule

FILE: src/ordered_set_membership_table.sv
// Top level of the ordered set membership table: cell chain, control and result beat.
//
//   channel | dir | payload | handshake
//   --------+-----+---------+----------------------------
//   in      | in  | t_req   | i_in_valid  / o_in_stall
//   out     | out | t_rsp   | o_out_valid / i_out_stall
//
// Results: read, clear and unused codes are answered in the cycle after the request beat.
//   Insert, remove and lookup send a token down the chain of CAPACITY cells,
//   one cell per cycle, behind a start register; the result beat is registered
//   from the chain's end, and the next request is taken once the block is idle again.
// Reset: synchronous, active low; clears fill level, token chain and handshake
//   state. Entry contents are not cleared.
// Stalls: a finished result waits in the output register; a scan request may be
//   accepted meanwhile, and a scan that ends while the output is held parks its
//   result until the output frees up.
module ordered_set_membership_table #(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  osmt_pkg::t_req   i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output osmt_pkg::t_rsp   o_out
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (OCC_W > osmt_pkg::INDEX_W) ? OCC_W : osmt_pkg::INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic [OCC_W-1:0]                    r_occ;
    logic [OCC_W-1:0]                    n_occ;
    logic [osmt_pkg::OP_W-1:0]           r_op;
    logic [osmt_pkg::OP_W-1:0]           n_op;
    logic signed [osmt_pkg::VALUE_W-1:0] r_key;
    logic signed [osmt_pkg::VALUE_W-1:0] n_key;
    logic                                r_start;
    logic                                n_start;
    logic                                r_out_valid;
    logic                                n_out_valid;
    osmt_pkg::t_rsp                      r_out;
    osmt_pkg::t_rsp                      n_out;
    osmt_pkg::t_rsp                      r_hold;
    osmt_pkg::t_rsp                      n_hold;

    logic                                w_out_free;
    logic                                w_accept;
    logic                                w_in_scan;
    logic                                w_done;
    logic                                w_found;
    logic                                w_in_range;
    logic [OCC_W-1:0]                    w_scan_occ;
    osmt_pkg::t_rsp                      w_scan_rsp;
    osmt_pkg::t_rsp                      w_quick_rsp;
    logic [OCC_W-1:0]                    w_quick_occ;
    osmt_pkg::t_cell_ctl                 w_ctl;

    osmt_pkg::t_link                     w_link [CAPACITY+1];
    logic signed [osmt_pkg::VALUE_W-1:0] w_val  [CAPACITY];
    logic signed [osmt_pkg::VALUE_W-1:0] w_win  [osmt_pkg::WINDOW];
    logic [CAPACITY:0]                   w_live;

    // ---------------------------------------------------------------
    // Cell chain. The token enters cell 0 the cycle after a scan beat
    // is accepted, passes one register in each cell, and leaves the
    // last cell with the accumulated hit flag.
    // ---------------------------------------------------------------
    assign w_link[0].tok = r_start;
    assign w_link[0].hit = 1'b0;
    assign w_ctl.insert  = (r_op == osmt_pkg::OP_INSERT);
    assign w_ctl.remove  = (r_op == osmt_pkg::OP_REMOVE);
    assign w_live[CAPACITY] = 1'b0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        osmt_pkg::t_slot                     w_slot;
        logic signed [osmt_pkg::VALUE_W-1:0] w_next;

        assign w_live[k]        = (r_occ > OCC_W'(k));
        assign w_slot.live      = w_live[k];
        assign w_slot.next_live = w_live[k+1];
        assign w_slot.tail      = (r_occ == OCC_W'(k));

        if (k == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_val[k+1];
        end

        osmt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_link       (w_link[k]),
            .i_ctl        (w_ctl),
            .i_slot       (w_slot),
            .i_key        (r_key),
            .i_next_value (w_next),
            .o_link       (w_link[k+1]),
            .o_value      (w_val[k])
        );
    end

    // read window: the first entries an index can reach
    for (genvar j = 0; j < osmt_pkg::WINDOW; j++) begin : g_win
        if (j < CAPACITY) begin : g_have
            assign w_win[j] = w_val[j];
        end else begin : g_none
            assign w_win[j] = '0;
        end
    end

    assign w_done  = w_link[CAPACITY].tok;
    assign w_found = w_link[CAPACITY].hit;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_in_scan  = (i_in.operation == osmt_pkg::OP_INSERT) ||
                        (i_in.operation == osmt_pkg::OP_REMOVE) ||
                        (i_in.operation == osmt_pkg::OP_LOOKUP);
    // scans may start while a result waits; read, clear and unused codes need the slot
    assign o_in_stall = !((r_state == S_IDLE) && (w_in_scan || w_out_free));
    assign w_accept   = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------
    // Result of a finished scan
    // ---------------------------------------------------------------
    always_comb begin
        w_scan_rsp            = '0;
        w_scan_occ            = r_occ;
        w_scan_rsp.found      = w_found;
        unique case (r_op)
            osmt_pkg::OP_INSERT: begin
                if (w_found) begin
                    w_scan_rsp.status = osmt_pkg::ST_PRESENT;
                end else if (r_occ == OCC_W'(CAPACITY)) begin
                    w_scan_rsp.status = osmt_pkg::ST_FULL;
                end else begin
                    w_scan_rsp.status = osmt_pkg::ST_OK;
                    w_scan_occ        = OCC_W'(r_occ + OCC_W'(1));
                end
            end
            osmt_pkg::OP_REMOVE: begin
                if (w_found) begin
                    w_scan_rsp.status = osmt_pkg::ST_OK;
                    w_scan_occ        = OCC_W'(r_occ - OCC_W'(1));
                end else begin
                    w_scan_rsp.status = osmt_pkg::ST_ABSENT;
                end
            end
            default: begin
                w_scan_rsp.status = w_found ? osmt_pkg::ST_OK : osmt_pkg::ST_ABSENT;
            end
        endcase
        w_scan_rsp.member_count = osmt_pkg::COUNT_W'(w_scan_occ);
    end

    // ---------------------------------------------------------------
    // Result of a quick request (read, clear, unused codes)
    // ---------------------------------------------------------------
    assign w_in_range = (CMP_W'(i_in.index) < CMP_W'(r_occ));

    always_comb begin
        w_quick_rsp = '0;
        w_quick_occ = r_occ;
        unique case (i_in.operation)
            osmt_pkg::OP_READ: begin
                if (w_in_range) begin
                    w_quick_rsp.status     = osmt_pkg::ST_OK;
                    w_quick_rsp.read_value = w_win[i_in.index];
                end else begin
                    // out of range answers the stale or live entry 0
                    w_quick_rsp.status     = osmt_pkg::ST_RANGE;
                    w_quick_rsp.read_value = w_val[0];
                end
            end
            osmt_pkg::OP_CLEAR: begin
                w_quick_occ = '0;
            end
            default: begin
                w_quick_rsp.status = osmt_pkg::ST_OK;
            end
        endcase
        w_quick_rsp.member_count = osmt_pkg::COUNT_W'(w_quick_occ);
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_op        = r_op;
        n_key       = r_key;
        n_start     = 1'b0;
        n_out       = r_out;
        n_hold      = r_hold;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_in_scan) begin
                        n_op    = i_in.operation;
                        n_key   = i_in.value;
                        n_start = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_occ       = w_quick_occ;
                        n_out       = w_quick_rsp;
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (w_done) begin
                    n_occ = w_scan_occ;
                    if (w_out_free) begin
                        n_out       = w_scan_rsp;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_hold  = w_scan_rsp;
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out       = r_hold;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    // the token only leaves the chain while a scan is running
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_SCAN))
        else $error("token left the chain outside a scan");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(CAPACITY))
        else $error("fill level above capacity");

    // an accepted read answers in the next cycle
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.operation == osmt_pkg::OP_READ)) |=> o_out_valid)
        else $error("read result beat missing");

    // a parked scan result exists only behind a pending output beat
    a_hold_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> o_out_valid)
        else $error("result parked while output free");
`endif

endmodule

FILE: dv/tb_ordered_set_membership_table.sv
// Testbench for the ordered set membership table: request/response scoreboard and beat drivers.
`timescale 1ns / 1ps
module tb_ordered_set_membership_table;

    localparam int CAPACITY       = 16;
    localparam int SCAN_CYCLES    = CAPACITY + 2;   // insert/remove/lookup walk the cell chain
    localparam int RANDOM_ITEMS   = 800;
    localparam int POOL_SIZE      = 24;             // more than CAPACITY so the table can fill
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 3000;           // must outlast the receiver hold-off
    localparam int HOLDOFF_CYCLES = 400;
    localparam int HOLDOFF_AFTER  = 200;            // responses checked before the hold-off
    localparam int DRAIN_AT_ITEM  = 500;

    // codes 5..7 are spare: no state change, ok status
    localparam logic [osmt_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [osmt_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    // Shadow of the set plus the queue of responses still owed by the block.
    class set_scoreboard;
        logic [osmt_pkg::VALUE_W-1:0] members [CAPACITY];
        int unsigned                  fill;
        bit                           head_written;   // entry 0 holds a real value since reset
        osmt_pkg::t_rsp               pending_rsps [$];
        int                           n_errors;
        int                           n_checked;
        int                           n_reported;

        function new();
            fill         = 0;
            head_written = 1'b0;
            n_errors     = 0;
            n_checked    = 0;
            n_reported   = 0;
            foreach (members[k]) members[k] = '0;
        endfunction

        function int position_of(logic [osmt_pkg::VALUE_W-1:0] v);
            int k;
            for (k = 0; k < fill; k++) begin
                if (members[k] == v) return k;
            end
            return -1;
        endfunction

        function int pending();
            return pending_rsps.size();
        endfunction

        // Apply one accepted request beat to the shadow and queue its response.
        function void note_request(osmt_pkg::t_req r);
            osmt_pkg::t_rsp rsp;
            int             pos;
            int             k;
            rsp        = '0;
            rsp.status = osmt_pkg::ST_OK;
            case (r.operation)
                osmt_pkg::OP_INSERT: begin
                    pos = position_of(r.value);
                    // presence wins over fullness
                    if (pos >= 0) begin
                        rsp.found  = 1'b1;
                        rsp.status = osmt_pkg::ST_PRESENT;
                    end else if (fill >= CAPACITY) begin
                        rsp.status = osmt_pkg::ST_FULL;
                    end else begin
                        members[fill] = r.value;
                        if (fill == 0) head_written = 1'b1;
                        fill++;
                    end
                end
                osmt_pkg::OP_REMOVE: begin
                    pos = position_of(r.value);
                    if (pos < 0) begin
                        rsp.status = osmt_pkg::ST_ABSENT;
                    end else begin
                        rsp.found = 1'b1;
                        // close the gap; the old tail entry stays behind as stale data
                        for (k = pos; k + 1 < fill; k++) members[k] = members[k + 1];
                        fill--;
                    end
                end
                osmt_pkg::OP_LOOKUP: begin
                    if (position_of(r.value) >= 0) rsp.found = 1'b1;
                    else rsp.status = osmt_pkg::ST_ABSENT;
                end
                osmt_pkg::OP_READ: begin
                    if (r.index < fill) begin
                        rsp.read_value = members[r.index];
                    end else begin
                        // out of range answers entry 0, stale or not
                        rsp.read_value = members[0];
                        rsp.status     = osmt_pkg::ST_RANGE;
                    end
                end
                osmt_pkg::OP_CLEAR: begin
                    fill = 0;
                end
                default: begin
                end
            endcase
            rsp.member_count = osmt_pkg::COUNT_W'(fill);
            pending_rsps.push_back(rsp);
        endfunction

        function void check_response(osmt_pkg::t_rsp got);
            osmt_pkg::t_rsp want;
            if (pending_rsps.size() == 0) begin
                n_errors++;
                if (n_reported < MAX_REPORTS) begin
                    n_reported++;
                    $display("unexpected response beat: st=%0d f=%0d n=%0d rd=%h",
                             got.status, got.found, got.member_count, got.read_value);
                end
                return;
            end
            want = pending_rsps.pop_front();
            n_checked++;
            if (got.status !== want.status || got.found !== want.found ||
                got.member_count !== want.member_count ||
                got.read_value !== want.read_value) begin
                n_errors++;
                if (n_reported < MAX_REPORTS) begin
                    n_reported++;
                    $display("mismatch on response %0d: exp st=%0d f=%0d n=%0d rd=%h",
                             n_checked, want.status, want.found, want.member_count,
                             want.read_value);
                    $display("                          got st=%0d f=%0d n=%0d rd=%h",
                             got.status, got.found, got.member_count, got.read_value);
                end
            end
        endfunction
    endclass

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_stall;
    osmt_pkg::t_req i_in        = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    osmt_pkg::t_rsp o_out;

    set_scoreboard sb = new();

    // value pool: extremes, alternating bit patterns, then random words
    logic [osmt_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];

    bit tx_may_idle   = 1'b1;
    int rx_cycle      = 0;
    int holdoff_left  = 0;
    bit holdoff_done  = 1'b0;
    int stuck_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ordered_set_membership_table #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    function automatic osmt_pkg::t_req make_req(logic [osmt_pkg::OP_W-1:0] op,
                                                logic [osmt_pkg::VALUE_W-1:0] v,
                                                logic [osmt_pkg::INDEX_W-1:0] idx);
        osmt_pkg::t_req r;
        r.operation = op;
        r.value     = v;
        r.index     = idx;
        return r;
    endfunction

    // Half the time a remove/lookup targets a live member so hits are common.
    function automatic logic [osmt_pkg::VALUE_W-1:0] pick_value(bit prefer_member);
        if (prefer_member && sb.fill > 0 && $urandom_range(0, 1) == 1)
            return sb.members[$urandom_range(0, sb.fill - 1)];
        if ($urandom_range(0, 99) < 85)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Fill-heavy stretches push the table to full; balanced ones churn it.
    function automatic osmt_pkg::t_req random_request(bit fill_heavy);
        osmt_pkg::t_req r;
        int             roll;
        int             ins_w;
        ins_w       = fill_heavy ? 60 : 38;
        roll        = $urandom_range(0, 99);
        r.value     = pick_value(1'b0);
        r.index     = osmt_pkg::INDEX_W'($urandom_range(0, osmt_pkg::WINDOW - 1));
        if (roll < ins_w) begin
            r.operation = osmt_pkg::OP_INSERT;
        end else if (roll < ins_w + 18) begin
            r.operation = osmt_pkg::OP_REMOVE;
            r.value     = pick_value(1'b1);
        end else if (roll < ins_w + 34) begin
            r.operation = osmt_pkg::OP_LOOKUP;
            r.value     = pick_value(1'b1);
        end else if (roll < 96) begin
            r.operation = osmt_pkg::OP_READ;
            if (sb.fill > 0 && $urandom_range(0, 1) == 1)
                r.index = osmt_pkg::INDEX_W'($urandom_range(0, sb.fill - 1));
        end else if (roll < 98) begin
            r.operation = osmt_pkg::OP_CLEAR;
        end else begin
            r.operation = osmt_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        // entry 0 is undefined until the first insert lands; never read it before then
        if (r.operation == osmt_pkg::OP_READ && !sb.head_written)
            r.operation = osmt_pkg::OP_INSERT;
        return r;
    endfunction

    // Offer one request beat and hold it until the block takes it.
    task automatic send_beat(input osmt_pkg::t_req r);
        while (tx_may_idle && $urandom_range(0, 99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(r);
    endtask

    // Drop valid and wait for every owed response; always waits on the clock before the
    // first check, so valid is never lowered and raised in the same step.
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int k;
        int n;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        value_pool[5] = 32'hAAAA_AAAA;
        value_pool[6] = 32'h5555_5555;
        for (k = 7; k < POOL_SIZE; k++) value_pool[k] = $urandom;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // empty table: lookup and remove both miss
        send_beat(make_req(osmt_pkg::OP_LOOKUP, value_pool[2], '0));
        send_beat(make_req(osmt_pkg::OP_REMOVE, value_pool[0], '0));
        // fill to capacity, extremes first
        for (k = 0; k < CAPACITY; k++)
            send_beat(make_req(osmt_pkg::OP_INSERT, value_pool[k], '0));
        send_beat(make_req(osmt_pkg::OP_INSERT, value_pool[3], '0));         // already present
        send_beat(make_req(osmt_pkg::OP_INSERT, value_pool[CAPACITY], '0));  // full, refused
        send_beat(make_req(osmt_pkg::OP_LOOKUP, value_pool[CAPACITY - 1], '0));
        // last slot in range
        send_beat(make_req(osmt_pkg::OP_READ, '0, osmt_pkg::INDEX_W'(CAPACITY - 1)));
        send_beat(make_req(osmt_pkg::OP_REMOVE, value_pool[0], '0));         // head removal
        // now out of range
        send_beat(make_req(osmt_pkg::OP_READ, '0, osmt_pkg::INDEX_W'(CAPACITY - 1)));
        send_beat(make_req(osmt_pkg::OP_READ, '1, '0));
        send_beat(make_req(osmt_pkg::OP_CLEAR, '0, '0));
        send_beat(make_req(osmt_pkg::OP_READ, '0, '0));                      // stale entry 0
        send_beat(make_req(OP_SPARE_LAST, '1, '1));
        wait_until_drained();

        // --- random ---
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            tx_may_idle = !(n >= 300 && n < 450);   // back-to-back stretch
            if (n == DRAIN_AT_ITEM) wait_until_drained();
            send_beat(random_request((n / 50) % 3 == 1));
        end

        wait_until_drained();
        repeat (2 * SCAN_CYCLES) @(posedge i_clk);

        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            if (sb.pending() != 0)
                $display("%0d responses never arrived", sb.pending());
            $display("Some tests failed");
        end
        $finish;
    end

    // Response side: check on accept, then pick the next stall value.
    initial begin
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_response(o_out);
            // one long hold-off mid-run while requests keep coming
            if (!holdoff_done && sb.n_checked >= HOLDOFF_AFTER) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_out_stall <= 1'b1;
            end else if (rx_cycle >= 3000 && rx_cycle < 5000) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 6);
            end
        end
    end

    // Watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", stuck_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
